// ----- rtl/core/bmdf_pkg.sv -----
// Package for the binary mask density filter.
// Holds the sizing constants, register index codes and the position record type.
// No dependencies.
package bmdf_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int CfgWidW  = 11;
  localparam int CmpW     = (CfgWidW > ColW + 1) ? CfgWidW : ColW + 1;
  localparam int HgtW     = 16;
  localparam int PixW     = 8;
  localparam int DenW     = 4;
  localparam int CntW     = 4;

  localparam logic [1:0] RegMinDensity = 2'd0;
  localparam logic [1:0] RegFgValue    = 2'd1;
  localparam logic [1:0] RegImgWidth   = 2'd2;
  localparam logic [1:0] RegImgHeight  = 2'd3;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic            produce;
    logic            last;
  } pos_info_t;

endpackage

// ----- rtl/core/bmdf_line_mem.sv -----
// Line store for the density filter: two mask bits per column.
// Synchronous memory with one read and one write port, read data registered.
// Depends on bmdf_pkg.
module bmdf_line_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [bmdf_pkg::ColW-1:0] rd_addr,
  output logic [1:0]                rd_data,
  input  logic                      wr_en,
  input  logic [bmdf_pkg::ColW-1:0] wr_addr,
  input  logic [1:0]                wr_data
);

  logic [1:0] mem [bmdf_pkg::MaxWidth];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/bmdf_pos.sv -----
// Raster position counters for the density filter.
// Decides per accepted beat whether an interior result follows and whether it ends the frame.
// Depends on bmdf_pkg.
module bmdf_pos (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         frame_start,
  input  logic [bmdf_pkg::CfgWidW-1:0] img_width,
  input  logic [bmdf_pkg::HgtW-1:0]    img_height,
  output bmdf_pkg::pos_info_t          info
);

  logic [bmdf_pkg::ColW-1:0] col_r, col_nxt;
  logic [bmdf_pkg::HgtW-1:0] row_r, row_nxt;
  logic [bmdf_pkg::ColW-1:0] col_cur;
  logic [bmdf_pkg::HgtW-1:0] row_cur;
  logic [bmdf_pkg::CmpW-1:0] w_full, w_use, col_ext, col_plus;
  logic [bmdf_pkg::HgtW-1:0] h_use;
  logic [bmdf_pkg::HgtW:0]   row_plus;

  always_comb begin
    w_full = bmdf_pkg::CmpW'(img_width);
    if (w_full < bmdf_pkg::CmpW'(3)) begin
      w_use = bmdf_pkg::CmpW'(3);
    end else if (w_full > bmdf_pkg::CmpW'(bmdf_pkg::MaxWidth)) begin
      w_use = bmdf_pkg::CmpW'(bmdf_pkg::MaxWidth);
    end else begin
      w_use = w_full;
    end
    h_use = (img_height < bmdf_pkg::HgtW'(3)) ? bmdf_pkg::HgtW'(3) : img_height;

    col_cur  = frame_start ? '0 : col_r;
    row_cur  = frame_start ? '0 : row_r;
    col_ext  = bmdf_pkg::CmpW'(col_cur);
    col_plus = col_ext + bmdf_pkg::CmpW'(1);
    row_plus = {1'b0, row_cur} + (bmdf_pkg::HgtW+1)'(1);

    info.col     = col_cur;
    info.produce = (row_cur >= bmdf_pkg::HgtW'(2)) && (col_ext >= bmdf_pkg::CmpW'(2)) &&
                   (row_cur < h_use) && (col_ext < w_use);
    info.last    = (row_cur == h_use - bmdf_pkg::HgtW'(1)) &&
                   (col_ext == w_use - bmdf_pkg::CmpW'(1));

    if (col_plus >= w_use) begin
      col_nxt = '0;
      row_nxt = (row_plus >= {1'b0, h_use}) ? '0 : row_plus[bmdf_pkg::HgtW-1:0];
    end else begin
      col_nxt = col_plus[bmdf_pkg::ColW-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- rtl/core/bmdf_window.sv -----
// 3x3 window and neighbor count of the density filter.
// Builds the current column from the line store word, counts neighbors and decides the result.
// Depends on bmdf_pkg.
module bmdf_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       fg_bit,
  input  logic [1:0]                 rd_word,
  input  logic [bmdf_pkg::DenW-1:0]  min_density,
  input  logic [bmdf_pkg::PixW-1:0]  fg_value,
  output logic [1:0]                 wr_word,
  output logic [bmdf_pkg::PixW-1:0]  result
);

  logic [5:0] window_r, window_nxt;
  logic [2:0] cur_col, prev, older;
  logic [bmdf_pkg::CntW-1:0] count;

  always_comb begin
    cur_col = {fg_bit, rd_word[1], rd_word[0]};
    prev    = window_r[2:0];
    older   = window_r[5:3];
    count   = bmdf_pkg::CntW'(older[0]) + bmdf_pkg::CntW'(older[1]) +
              bmdf_pkg::CntW'(older[2]) + bmdf_pkg::CntW'(cur_col[0]) +
              bmdf_pkg::CntW'(cur_col[1]) + bmdf_pkg::CntW'(cur_col[2]) +
              bmdf_pkg::CntW'(prev[0]) + bmdf_pkg::CntW'(prev[2]);
    result  = (prev[1] && (count >= min_density)) ? fg_value : '0;
    wr_word = {fg_bit, rd_word[1]};
    window_nxt = {prev, cur_col};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (step) begin
      window_r <= window_nxt;
    end
  end

endmodule

// ----- rtl/core/binary_mask_density_filter.sv -----
// Binary 3x3 density filter on a raster-order stream of mask pixels.
// Input beats carry one pixel in in_tdata and the frame start flag in in_tuser.
// Each pixel is compared with fg_value; the bit goes into a line store memory and a
// 3x3 window. Interior pixels give one output beat: fg_value if the center is
// foreground and at least min_density of its eight neighbors are, else zero.
// Border pixels give no beat. out_tlast marks the last interior result of a frame.
// One pixel is accepted per cycle unless a receiver stall fills both stages. Each
// beat passes through the line store read stage and then the output register.
// The line store is read at one column when a beat is accepted and written back
// when the beat leaves the read stage; a repeat of the same column in consecutive
// beats is forwarded around the memory. When the receiver stalls, the output
// register and the read stage hold and in_tready drops only while both are full.
// Reset clears the counters, the window and the valid flags and loads the register
// defaults (min_density 4, fg_value 255, 640 by 480). The line store is not cleared.
// The user must write registers through the APB port only while no pixel is in flight; the block does not enforce this.
module binary_mask_density_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] filtered_pixel
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [bmdf_pkg::DenW-1:0]    min_density_r;
  logic [bmdf_pkg::PixW-1:0]    fg_value_r;
  logic [bmdf_pkg::CfgWidW-1:0] img_width_r;
  logic [bmdf_pkg::HgtW-1:0]    img_height_r;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;

  logic                         in_acc, adv;
  bmdf_pkg::pos_info_t          pos;
  logic                         in_bit;

  logic                         s1_v_r;
  logic [bmdf_pkg::ColW-1:0]    s1_col_r;
  logic                         s1_bit_r, s1_produce_r, s1_last_r;
  logic                         fwd_hit_r;
  logic [1:0]                   fwd_word_r;
  logic                         fwd_hit_nxt;

  logic [1:0]                   mem_rd, rd_word, wr_word;
  logic [bmdf_pkg::PixW-1:0]    result;

  logic                         out_v_r;
  logic [bmdf_pkg::PixW-1:0]    out_data_r;
  logic                         out_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_density_r <= bmdf_pkg::DenW'(4);
      fg_value_r    <= bmdf_pkg::PixW'(255);
      img_width_r   <= bmdf_pkg::CfgWidW'(640);
      img_height_r  <= bmdf_pkg::HgtW'(480);
    end else if (cfg_wr) begin
      case (cfg_idx)
        bmdf_pkg::RegMinDensity: min_density_r <= cfg_pwdata[bmdf_pkg::DenW-1:0];
        bmdf_pkg::RegFgValue:    fg_value_r    <= cfg_pwdata[bmdf_pkg::PixW-1:0];
        bmdf_pkg::RegImgWidth:   img_width_r   <= cfg_pwdata[bmdf_pkg::CfgWidW-1:0];
        bmdf_pkg::RegImgHeight:  img_height_r  <= cfg_pwdata[bmdf_pkg::HgtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bmdf_pkg::RegMinDensity: cfg_prdata = 32'(min_density_r);
      bmdf_pkg::RegFgValue:    cfg_prdata = 32'(fg_value_r);
      bmdf_pkg::RegImgWidth:   cfg_prdata = 32'(img_width_r);
      bmdf_pkg::RegImgHeight:  cfg_prdata = 32'(img_height_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign in_bit    = (in_tdata == fg_value_r);

  bmdf_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .frame_start (in_tuser),
    .img_width   (img_width_r),
    .img_height  (img_height_r),
    .info        (pos)
  );

  bmdf_line_mem u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos.col),
    .rd_data (mem_rd),
    .wr_en   (adv),
    .wr_addr (s1_col_r),
    .wr_data (wr_word)
  );

  assign fwd_hit_nxt = adv && (s1_col_r == pos.col);
  assign rd_word     = fwd_hit_r ? fwd_word_r : mem_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r     <= pos.col;
      s1_bit_r     <= in_bit;
      s1_produce_r <= pos.produce;
      s1_last_r    <= pos.last;
      fwd_hit_r    <= fwd_hit_nxt;
      fwd_word_r   <= wr_word;
    end
  end

  bmdf_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .fg_bit      (s1_bit_r),
    .rd_word     (rd_word),
    .min_density (min_density_r),
    .fg_value    (fg_value_r),
    .wr_word     (wr_word),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_produce_r;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled while a stage was free");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_col_r) && $stable(s1_bit_r)))
    else $error("read stage lost its beat during a stall");

  a_forward_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && adv && (s1_col_r == pos.col)) |=> fwd_hit_r)
    else $error("back to back access to one column not forwarded");

  a_out_only_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(adv && s1_produce_r))
    else $error("output beat without an interior pixel behind it");

endmodule
